// ===== rtl/rbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rbe_pkg
// shared types, codes and pixel format helpers of the rgb332 blit engine
// ----------------------------------------------------------------------------
`default_nettype none

package rbe_pkg;

  localparam int MAX_DIM_DEF  = 2048;
  localparam int FB_BYTES_DEF = 1048576;
  localparam int Q_DEPTH      = 4;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_FILL  = 2'd1,
    OP_WRITE = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_ARG = 2'd1,
    ST_BOUNDS  = 2'd2,
    ST_IDLE    = 2'd3
  } status_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BLIT_OP       = 3'd2;
  localparam logic [2:0] REG_VIDEO_X       = 3'd3;
  localparam logic [2:0] REG_VIDEO_Y       = 3'd4;
  localparam logic [2:0] REG_RECT_WIDTH    = 3'd5;
  localparam logic [2:0] REG_RECT_HEIGHT   = 3'd6;
  localparam logic [2:0] REG_FILL_COLOR    = 3'd7;

  localparam logic [7:0] MASK_RED   = 8'he0;
  localparam logic [7:0] MASK_GREEN = 8'h1c;
  localparam logic [7:0] MASK_BLUE  = 8'h03;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    op_t         blit_op;
    logic [10:0] video_x;
    logic [10:0] video_y;
    logic [11:0] rect_width;
    logic [11:0] rect_height;
    logic [23:0] fill_color;
  } cfg_t;

  // one classified item as it travels from front to back
  typedef struct packed {
    logic       is_step;
    status_t    status;
    logic       wr;
    logic [7:0] mem_byte;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } entry_t;

  function automatic logic [7:0] pack332(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    pack332 = (r & MASK_RED) | ((g >> 3) & MASK_GREEN) | ((b >> 6) & MASK_BLUE);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rbe_front.sv =====
// ----------------------------------------------------------------------------
// rbe_front
// classifies items: start checks and row base, pixel packing and expansion
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_front #(
  parameter int MAX_DIM = 2048,
  parameter int ADDR_W  = 20
) (
  input  rbe_pkg::cfg_t   cfg,
  input  logic            cmd,
  input  logic [7:0]      red_in,
  input  logic [7:0]      green_in,
  input  logic [7:0]      blue_in,
  input  logic [7:0]      video_byte,
  output rbe_pkg::entry_t entry,
  output logic [ADDR_W-1:0] row_base
);
  import rbe_pkg::*;

  logic        bad_arg;
  logic        oob;
  logic [22:0] prod;
  logic [24:0] base_sum;

  assign prod     = cfg.video_y * cfg.screen_width;
  assign base_sum = 25'(prod) + 25'(cfg.video_x);
  // frame buffer size is a power of two, so the wrap is a truncation
  assign row_base = base_sum[ADDR_W-1:0];

  assign bad_arg = (cfg.blit_op == OP_BAD) || (cfg.rect_width == '0) ||
                   (cfg.rect_height == '0);
  assign oob = (13'(cfg.rect_width) > 13'(MAX_DIM)) ||
               (13'(cfg.rect_height) > 13'(MAX_DIM)) ||
               (13'(cfg.video_y) + 13'(cfg.rect_height) > 13'(cfg.screen_height)) ||
               (13'(cfg.video_x) + 13'(cfg.rect_width) > 13'(cfg.screen_width));

  always_comb begin
    entry          = '0;
    entry.is_step  = (cmd == CMD_STEP);
    entry.status   = bad_arg ? ST_BAD_ARG : (oob ? ST_BOUNDS : ST_OK);
    case (cfg.blit_op)
      OP_READ: begin
        entry.red   = video_byte & MASK_RED;
        entry.green = {video_byte[4:2], 5'b0};
        entry.blue  = {video_byte[1:0], 6'b0};
      end
      OP_FILL: begin
        entry.wr       = 1'b1;
        entry.mem_byte = pack332(cfg.fill_color[23:16], cfg.fill_color[15:8],
                                 cfg.fill_color[7:0]);
      end
      default: begin
        entry.wr       = 1'b1;
        entry.mem_byte = pack332(red_in, green_in, blue_in);
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rbe_queue.sv =====
// ----------------------------------------------------------------------------
// rbe_queue
// short first-word-fall-through queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rbe_back.sv =====
// ----------------------------------------------------------------------------
// rbe_back
// blit state, address walk and the registered result stage
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_back #(
  parameter int MAX_DIM = 2048,
  parameter int ADDR_W  = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  rbe_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  rbe_pkg::entry_t   q_entry,
  input  logic [ADDR_W-1:0] q_row_base,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [ADDR_W-1:0] mem_addr,
  output logic              mem_write,
  output logic [7:0]        mem_byte,
  output logic [7:0]        red_out,
  output logic [7:0]        green_out,
  output logic [7:0]        blue_out,
  output logic              word_access_ok,
  output logic              last
);
  import rbe_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);

  logic              active;
  logic [CNT_W-1:0]  column_count;
  logic [CNT_W-1:0]  row_count;
  logic [ADDR_W-1:0] row_base_addr;

  logic [CNT_W:0]    col_inc;
  logic [CNT_W:0]    row_inc;
  logic              row_end;
  logic              is_last;
  logic              full_area;
  logic [3:0]        top_lo;
  logic [3:0]        area_lo;
  logic              word_ok;
  logic [ADDR_W-1:0] addr;

  assign q_pop = q_valid && (!out_valid || !out_stall);

  assign col_inc = (CNT_W + 1)'(column_count) + 1'b1;
  assign row_inc = (CNT_W + 1)'(row_count) + 1'b1;
  assign row_end = 13'(col_inc) >= 13'(cfg.rect_width);
  assign is_last = row_end && (13'(row_inc) >= 13'(cfg.rect_height));
  assign addr    = row_base_addr + ADDR_W'(column_count);

  // fill over whole rows is one run, so alignment follows the whole area
  assign full_area = (cfg.blit_op == OP_FILL) && (cfg.video_x == '0) &&
                     (cfg.rect_width == cfg.screen_width);
  assign top_lo  = cfg.video_y[1:0] * cfg.screen_width[1:0];
  assign area_lo = cfg.rect_width[1:0] * cfg.rect_height[1:0];
  assign word_ok = full_area ? ((top_lo[1:0] == 2'b0) && (area_lo[1:0] == 2'b0))
                             : ((row_base_addr[1:0] == 2'b0) &&
                                (cfg.rect_width[1:0] == 2'b0));

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      column_count  <= '0;
      row_count     <= '0;
      row_base_addr <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        if (!q_entry.is_step) begin
          active <= (q_entry.status == ST_OK);
          if (q_entry.status == ST_OK) begin
            column_count  <= '0;
            row_count     <= '0;
            row_base_addr <= q_row_base;
          end
        end else if (active) begin
          if (is_last) begin
            active <= 1'b0;
          end else if (row_end) begin
            column_count  <= '0;
            row_count     <= row_inc[CNT_W-1:0];
            row_base_addr <= row_base_addr + ADDR_W'(cfg.screen_width);
          end else begin
            column_count <= col_inc[CNT_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status         <= ST_OK;
      mem_addr       <= '0;
      mem_write      <= 1'b0;
      mem_byte       <= '0;
      red_out        <= '0;
      green_out      <= '0;
      blue_out       <= '0;
      word_access_ok <= 1'b0;
      last           <= 1'b0;
      if (!q_entry.is_step) begin
        status <= q_entry.status;
      end else if (!active) begin
        status <= ST_IDLE;
      end else begin
        mem_addr       <= addr;
        mem_write      <= q_entry.wr;
        mem_byte       <= q_entry.mem_byte;
        red_out        <= q_entry.red;
        green_out      <= q_entry.green;
        blue_out       <= q_entry.blue;
        word_access_ok <= word_ok;
        last           <= is_last;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rgb332_blit_engine_unit.sv =====
// ----------------------------------------------------------------------------
// rgb332_blit_engine_unit
// rectangle blitter over an rgb332 frame buffer, one result per item
// flow: an accepted item is pushed into the queue, and its result is registered
// in the back stage when the item is popped
// throughput: one item per cycle while no result is held by out_stall, set by the address walk
// a four-entry queue parts front and back, so input takes up to four more
// items while a result is held by out_stall
// reset: synchronous; registers return to 640x480 and zeros, blit goes idle
// ----------------------------------------------------------------------------
`default_nettype none

module rgb332_blit_engine_unit #(
  parameter int MAX_DIM  = rbe_pkg::MAX_DIM_DEF,
  parameter int FB_BYTES = rbe_pkg::FB_BYTES_DEF,
  parameter int ADDR_W   = $clog2(FB_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [7:0]        red_in,
  input  logic [7:0]        green_in,
  input  logic [7:0]        blue_in,
  input  logic [7:0]        video_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [ADDR_W-1:0] mem_addr,
  output logic              mem_write,
  output logic [7:0]        mem_byte,
  output logic [7:0]        red_out,
  output logic [7:0]        green_out,
  output logic [7:0]        blue_out,
  output logic              word_access_ok,
  output logic              last
);
  import rbe_pkg::*;

  localparam int QW = $bits(entry_t) + ADDR_W;

  cfg_t              cfg;
  entry_t            f_entry;
  logic [ADDR_W-1:0] f_row_base;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [QW-1:0]     q_head;
  entry_t            q_entry;
  logic [ADDR_W-1:0] q_row_base;
  logic              push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 12'd640;
      cfg.screen_height <= 12'd480;
      cfg.blit_op       <= OP_READ;
      cfg.video_x       <= '0;
      cfg.video_y       <= '0;
      cfg.rect_width    <= '0;
      cfg.rect_height   <= '0;
      cfg.fill_color    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[11:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[11:0];
        REG_BLIT_OP:       cfg.blit_op       <= op_t'(cfg_data[1:0]);
        REG_VIDEO_X:       cfg.video_x       <= cfg_data[10:0];
        REG_VIDEO_Y:       cfg.video_y       <= cfg_data[10:0];
        REG_RECT_WIDTH:    cfg.rect_width    <= cfg_data[11:0];
        REG_RECT_HEIGHT:   cfg.rect_height   <= cfg_data[11:0];
        REG_FILL_COLOR:    cfg.fill_color    <= cfg_data;
        default: ;
      endcase
    end
  end

  rbe_front #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_front (
    .cfg        (cfg),
    .cmd        (cmd),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .video_byte (video_byte),
    .entry      (f_entry),
    .row_base   (f_row_base)
  );

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  rbe_queue #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_entry, f_row_base}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  assign q_entry    = entry_t'(q_head[QW-1:ADDR_W]);
  assign q_row_base = q_head[ADDR_W-1:0];

  rbe_back #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_row_base     (q_row_base),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .mem_addr       (mem_addr),
    .mem_write      (mem_write),
    .mem_byte       (mem_byte),
    .red_out        (red_out),
    .green_out      (green_out),
    .blue_out       (blue_out),
    .word_access_ok (word_access_ok),
    .last           (last)
  );

endmodule

`default_nettype wire
